// File: sv/gwai_pkg.sv
// Shared types and constants of the gyro window angle integrator.
package gwai_pkg;

    localparam int RATE_W    = 16;
    localparam int SUM_W     = 20;
    localparam int GAIN_W    = 16;
    localparam int ANGLE_W   = 8;
    localparam int PROD_W    = SUM_W + GAIN_W;
    localparam int ANG_SUM_W = SUM_W + 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd2294;
    localparam logic [ANGLE_W-1:0] MAX_RESET   = 8'd180;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 1'd1;

    // Step controls that the sequencer broadcasts to every axis lane.
    typedef struct packed {
        logic load;     // capture the raw rate of an accepted transaction
        logic scale;    // register the raw rate divided by the rate scale
        logic start;    // launch the lane divider on the window sum
        logic acc;      // add the scaled rate into the window sum
        logic mul;      // register average times gain
        logic ang;      // commit the new angle and clear the sum
    } lane_ctrl_t;

endpackage

// File: sv/gwai_div.sv
// Restoring serial divider, one quotient bit per cycle.
module gwai_div #(
    parameter int DW = 20,
    parameter int VW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [VW-1:0]    rem_reg;
    logic [DW-1:0]    quo_reg;

    logic [VW:0] shifted;
    logic [VW:0] diff;
    logic        ge;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign ge      = !diff[VW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : shifted[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/gwai_lane.sv
// One axis lane: rate scaling, window sum, averaging, gain and angle clamp.
module gwai_lane #(
    parameter int VW           = 17,
    parameter int RATE_DIVISOR = 131
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gwai_pkg::lane_ctrl_t                ctrl,
    input  logic signed [gwai_pkg::RATE_W-1:0]  rate,
    input  logic [VW-1:0]                       divisor,
    input  logic [gwai_pkg::GAIN_W-1:0]         gain,
    input  logic [gwai_pkg::ANGLE_W-1:0]        max_angle,
    output logic                                busy,
    output logic [gwai_pkg::ANGLE_W-1:0]        angle_next
);

    localparam int RW = gwai_pkg::RATE_W;
    localparam int SW = gwai_pkg::SUM_W;
    localparam int PW = gwai_pkg::PROD_W;
    localparam int AW = gwai_pkg::ANG_SUM_W;
    localparam int GW = gwai_pkg::GAIN_W;
    localparam int NW = gwai_pkg::ANGLE_W;

    // The rate scale is a reciprocal multiply. The reciprocal is rounded up with
    // enough fraction bits that the quotient is exact for every rate magnitude.
    localparam int RDW     = $clog2(RATE_DIVISOR + 1);
    localparam int SHIFT   = RW + RDW;
    localparam int RECIP_W = RW + 2;
    localparam int SPW     = RW + 1 + RECIP_W;
    localparam int QW      = SPW - SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + RATE_DIVISOR - 1) / RATE_DIVISOR);

    logic signed [RW-1:0] rate_reg;
    logic signed [SW:0]   rate_q_reg;
    logic signed [SW-1:0] sum_reg;
    logic [NW-1:0]        angle_reg;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;

    logic [RW:0]          rate_ext;
    logic [RW:0]          rate_abs;
    logic [SPW-1:0]       scale_prod;
    logic [SW:0]          sum_ext;
    logic [SW:0]          sum_abs;
    logic [SW-1:0]        dividend;
    logic [SW-1:0]        quo;
    logic signed [SW:0]   q_ext;
    logic signed [SW:0]   rate_q;
    logic signed [SW:0]   sum_wide;
    logic signed [SW-1:0] sum_sat;
    logic [PW-1:0]        prod;
    logic signed [AW-1:0] ang_ext;
    logic signed [AW-1:0] mag_ext;
    logic signed [AW-1:0] ang_sum;

    // Truncation toward zero: the magnitude is scaled and the sign put back.
    assign rate_ext   = {rate_reg[RW-1], rate_reg};
    assign rate_abs   = rate_reg[RW-1] ? -rate_ext : rate_ext;
    assign scale_prod = SPW'(rate_abs) * SPW'(RECIP);
    assign q_ext      = $signed({{(SW + 1 - QW){1'b0}}, scale_prod[SPW-1:SHIFT]});
    assign rate_q     = rate_reg[RW-1] ? -q_ext : q_ext;

    // The magnitude of the window sum feeds the divider.
    assign sum_ext  = {sum_reg[SW-1], sum_reg};
    assign sum_abs  = sum_reg[SW-1] ? -sum_ext : sum_ext;
    assign dividend = sum_abs[SW-1:0];

    gwai_div #(
        .DW (SW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (busy),
        .quotient (quo)
    );

    assign sum_wide = sum_ext + rate_q_reg;

    always_comb
    begin
        if (sum_wide[SW] != sum_wide[SW-1])
        begin
            sum_sat = sum_wide[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SW-1:0];
        end
    end

    assign prod = PW'(quo) * PW'(gain);

    // The angle moves by the truncated gain product and is clamped to 0..max.
    assign ang_ext = $signed({{(AW - NW){1'b0}}, angle_reg});
    assign mag_ext = $signed({2'b00, prod_reg[PW-1:GW]});
    assign ang_sum = neg_reg ? ang_ext - mag_ext : ang_ext + mag_ext;

    always_comb
    begin
        if (ang_sum[AW-1])
        begin
            angle_next = '0;
        end
        else if (ang_sum > $signed({{(AW - NW){1'b0}}, max_angle}))
        begin
            angle_next = max_angle;
        end
        else
        begin
            angle_next = ang_sum[NW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            angle_reg <= gwai_pkg::ANGLE_RESET;
        end
        else if (ctrl.ang)
        begin
            sum_reg   <= '0;
            angle_reg <= angle_next;
        end
        else if (ctrl.acc)
        begin
            sum_reg <= sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rate_reg <= rate;
        end
        if (ctrl.scale)
        begin
            rate_q_reg <= rate_q;
        end
        if (ctrl.mul)
        begin
            prod_reg <= prod;
            neg_reg  <= sum_reg[SW-1];
        end
    end

endmodule

// File: sv/gyro_window_angle_integrator.sv
// Top level of the gyro window angle integrator: sequencer, three axis lanes, output register.
//
//   Channel  Signals                                    Direction  Moves
//   input    in_valid in_ready rate_x/y/z window_end    in         one gyro sample
//   output   out_valid out_ready tilt/pitch/pan_angle    out        three updated angles
//   config   cfg_we cfg_index cfg_data                  in         one register write
//
// A sample that does not close the window goes through the scale and add steps
// before the next input transaction is taken: the rate is scaled by a reciprocal
// multiply, then added into the window sum. A closing sample goes on after the add:
// the serial divider in each lane averages the sum over the sample count, then come
// the gain multiply and the angle commit.
// Reset clears the sums and the count, sets every angle to 90 and the registers
// to their defaults. The finished angles wait in an output register, so the next
// sample is taken while a result is still pending; only a second result stalls
// until the first output transaction completes.
module gyro_window_angle_integrator #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int RATE_DIVISOR = 131
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [gwai_pkg::RATE_W-1:0]     rate_x,
    input  logic signed [gwai_pkg::RATE_W-1:0]     rate_y,
    input  logic signed [gwai_pkg::RATE_W-1:0]     rate_z,
    input  logic                                   window_end,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [gwai_pkg::ANGLE_W-1:0]           tilt_angle,
    output logic [gwai_pkg::ANGLE_W-1:0]           pitch_angle,
    output logic [gwai_pkg::ANGLE_W-1:0]           pan_angle,
    input  logic                                   cfg_we,
    input  logic [gwai_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gwai_pkg::CFG_W-1:0]             cfg_data
);

    // Count width holds MAX_SAMPLES itself; the count is the divisor.
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int NW  = gwai_pkg::ANGLE_W;
    localparam int GW  = gwai_pkg::GAIN_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_SSTART = 3'd3;
    localparam logic [2:0] S_SWAIT  = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_ANG    = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] count_reg;
    logic          end_reg;
    logic [GW-1:0] gain_reg;
    logic [NW-1:0] max_reg;
    logic          out_valid_reg;
    logic [NW-1:0] tilt_reg;
    logic [NW-1:0] pitch_reg;
    logic [NW-1:0] pan_reg;

    gwai_pkg::lane_ctrl_t ctrl;
    logic [2:0]           lane_busy;
    logic                 busy_any;
    logic                 count_ok;
    logic                 in_fire;
    logic                 ang_fire;
    logic [NW-1:0]        tilt_next;
    logic [NW-1:0]        pitch_next;
    logic [NW-1:0]        pan_next;

    assign busy_any = |lane_busy;
    assign count_ok = count_reg < CW'(MAX_SAMPLES);
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign ang_fire = (state_reg == S_ANG) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        ctrl.load    = in_fire;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                ctrl.scale = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // A saturated count freezes the window sums.
                ctrl.acc   = count_ok;
                state_next = end_reg ? S_SSTART : S_IDLE;
            end
            S_SSTART:
            begin
                ctrl.start = 1'b1;
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (!busy_any)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = S_ANG;
            end
            S_ANG:
            begin
                // The angles commit only when the output register can take them.
                if (ang_fire)
                begin
                    ctrl.ang   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    gwai_lane #(.VW(CW), .RATE_DIVISOR(RATE_DIVISOR)) u_lane_tilt (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rate       (rate_x),
        .divisor    (count_reg),
        .gain       (gain_reg),
        .max_angle  (max_reg),
        .busy       (lane_busy[0]),
        .angle_next (tilt_next)
    );

    gwai_lane #(.VW(CW), .RATE_DIVISOR(RATE_DIVISOR)) u_lane_pitch (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rate       (rate_y),
        .divisor    (count_reg),
        .gain       (gain_reg),
        .max_angle  (max_reg),
        .busy       (lane_busy[1]),
        .angle_next (pitch_next)
    );

    gwai_lane #(.VW(CW), .RATE_DIVISOR(RATE_DIVISOR)) u_lane_pan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rate       (rate_z),
        .divisor    (count_reg),
        .gain       (gain_reg),
        .max_angle  (max_reg),
        .busy       (lane_busy[2]),
        .angle_next (pan_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            end_reg       <= 1'b0;
            gain_reg      <= gwai_pkg::GAIN_RESET;
            max_reg       <= gwai_pkg::MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                end_reg <= window_end;
            end
            if (ctrl.ang)
            begin
                count_reg <= '0;
            end
            else if (ctrl.acc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (ang_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gwai_pkg::REG_GAIN_Q16:  gain_reg <= cfg_data[GW-1:0];
                    gwai_pkg::REG_MAX_ANGLE: max_reg  <= cfg_data[NW-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    // Merging stage: the three lane angles are registered together.
    always_ff @(posedge clk)
    begin
        if (ang_fire)
        begin
            tilt_reg  <= tilt_next;
            pitch_reg <= pitch_next;
            pan_reg   <= pan_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tilt_angle  = tilt_reg;
    assign pitch_angle = pitch_reg;
    assign pan_angle   = pan_reg;

    // The lanes must be quiet whenever a new sample can be taken.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !busy_any)
        else $error("lane divider busy while input is ready");

    // The sample count never passes its saturation point.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count above saturation");

    // The count is cleared whenever a window closes.
    assert property (@(posedge clk) disable iff (!rst_n) ang_fire |=> count_reg == '0)
        else $error("count not cleared at window end");

    // Every committed window result shows up at the output.
    assert property (@(posedge clk) disable iff (!rst_n) ang_fire |=> out_valid)
        else $error("window result not presented");

endmodule

// File: sim/testbench.sv
// Self-checking testbench of the gyro window angle integrator, with its angle scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_SAMPLES    = 1024;
    localparam int RATE_DIVISOR   = 131;
    localparam int RATE_MAX       = 2 ** (gwai_pkg::RATE_W - 1) - 1;
    localparam int RATE_MIN       = -(2 ** (gwai_pkg::RATE_W - 1));
    localparam int SUM_MAX        = 2 ** (gwai_pkg::SUM_W - 1) - 1;
    localparam int SUM_MIN        = -(2 ** (gwai_pkg::SUM_W - 1));
    // The settle pause covers a non-closing sample that is still in flight
    // once the last result is out.
    localparam int SETTLE_CYCLES  = 120;
    // Longest legal quiet stretch is a settle pause plus a long receiver stall.
    localparam int WATCHDOG_LIMIT = 5000;

    typedef logic signed [gwai_pkg::RATE_W-1:0] rate_t;
    typedef logic [gwai_pkg::ANGLE_W-1:0]       angle_t;
    typedef logic [gwai_pkg::GAIN_W-1:0]        gain_t;
    typedef logic [gwai_pkg::CFG_W-1:0]         cfg_word_t;
    typedef logic [gwai_pkg::CFG_IDX_W-1:0]     cfg_idx_t;

    // One result transaction: the three clamped angles.
    typedef struct packed {
        angle_t tilt;
        angle_t pitch;
        angle_t pan;
    } angle_set_t;

    // The scoreboard keeps its own copy of the window sums, the sample count,
    // the angles and both registers, and queues the angles that each closing
    // sample should produce.
    class angle_tracker;
        int unsigned gain = gwai_pkg::GAIN_RESET;
        int          ceiling = gwai_pkg::MAX_RESET;
        int          sums[3] = '{0, 0, 0};
        int          count = 0;
        int          angles[3] = '{gwai_pkg::ANGLE_RESET, gwai_pkg::ANGLE_RESET,
                                   gwai_pkg::ANGLE_RESET};
        angle_set_t  pending_angles[$];
        int          errors = 0;
        int          checked = 0;
        int          windows = 0;
        int          saturated_windows = 0;

        function void set_reg(cfg_idx_t idx, cfg_word_t word);
            case (idx)
                gwai_pkg::REG_GAIN_Q16:  gain = word[gwai_pkg::GAIN_W-1:0];
                gwai_pkg::REG_MAX_ANGLE: ceiling = word[gwai_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        // Average the window sum, scale it by the gain magnitude-wise, and
        // apply the change to one angle with the clamp at both ends.
        function int close_axis(int angle, int sum);
            int     avg;
            longint mag;
            int     updated;
            avg = (count == 0) ? 0 : sum / count;
            mag = (avg < 0) ? -avg : avg;
            mag = (mag * longint'(gain)) >> 16;
            updated = (avg < 0) ? angle - int'(mag) : angle + int'(mag);
            if (updated < 0)
                updated = 0;
            if (updated > ceiling)
                updated = ceiling;
            return updated;
        endfunction

        function void take_sample(rate_t x, rate_t y, rate_t z, logic closing);
            int         scaled[3];
            int         total;
            angle_set_t want;
            scaled[0] = int'(x) / RATE_DIVISOR;
            scaled[1] = int'(y) / RATE_DIVISOR;
            scaled[2] = int'(z) / RATE_DIVISOR;
            // Once the count is saturated, further samples are dropped.
            if (count < MAX_SAMPLES)
            begin
                foreach (sums[a])
                begin
                    total = sums[a] + scaled[a];
                    sums[a] = (total > SUM_MAX) ? SUM_MAX : (total < SUM_MIN) ? SUM_MIN : total;
                end
                count++;
            end
            if (!closing)
                return;
            windows++;
            if (count == MAX_SAMPLES)
                saturated_windows++;
            foreach (angles[a])
                angles[a] = close_axis(angles[a], sums[a]);
            want.tilt  = angle_t'(angles[0]);
            want.pitch = angle_t'(angles[1]);
            want.pan   = angle_t'(angles[2]);
            pending_angles.push_back(want);
            sums  = '{0, 0, 0};
            count = 0;
        endfunction

        function void match_angles(angle_t tilt, angle_t pitch, angle_t pan);
            angle_set_t want;
            if (pending_angles.size() == 0)
            begin
                $error("angle result with nothing expected: tilt %0d pitch %0d pan %0d",
                       tilt, pitch, pan);
                errors++;
                return;
            end
            want = pending_angles.pop_front();
            checked++;
            if (tilt !== want.tilt)
            begin
                $error("tilt_angle: expected %0d, actual %0d", want.tilt, tilt);
                errors++;
            end
            if (pitch !== want.pitch)
            begin
                $error("pitch_angle: expected %0d, actual %0d", want.pitch, pitch);
                errors++;
            end
            if (pan !== want.pan)
            begin
                $error("pan_angle: expected %0d, actual %0d", want.pan, pan);
                errors++;
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    rate_t     rate_x = '0;
    rate_t     rate_y = '0;
    rate_t     rate_z = '0;
    logic      window_end = 1'b0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    angle_t    tilt_angle;
    angle_t    pitch_angle;
    angle_t    pan_angle;
    logic      cfg_we = 1'b0;
    cfg_idx_t  cfg_index = '0;
    cfg_word_t cfg_data = '0;

    angle_tracker tracker = new;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int samples_sent = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    gyro_window_angle_integrator dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .rate_x,
        .rate_y,
        .rate_z,
        .window_end,
        .out_valid,
        .out_ready,
        .tilt_angle,
        .pitch_angle,
        .pan_angle,
        .cfg_we,
        .cfg_index,
        .cfg_data
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The receiver decides at each falling edge whether to stall the next cycle.
    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Output transactions are checked at the rising edge that completes them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_angles(tilt_angle, pitch_angle, pan_angle);
    end

    // The watchdog ends a run in which no transaction completes for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Drives one sample as an input transaction. It is entered and left at a
    // falling edge; valid stays high on return so that a following sample can
    // go out back to back, and the caller lowers it before doing anything else.
    task automatic send_sample(input rate_t x, input rate_t y, input rate_t z,
                               input logic closing);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        rate_x     <= x;
        rate_y     <= y;
        rate_z     <= z;
        window_end <= closing;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_sample(x, y, z, closing);
        samples_sent++;
        @(negedge clk);
    endtask

    // Holds the sender until every expected result has arrived, then lets the
    // block finish whatever non-closing sample it may still be working on.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_angles.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both registers while the block is idle. The bits of the angle
    // write above the register width are random and must be ignored.
    task automatic configure(input gain_t gain, input angle_t ceiling);
        cfg_word_t word;
        drain();
        word = cfg_word_t'($urandom());
        word[gwai_pkg::ANGLE_W-1:0] = ceiling;
        cfg_we    <= 1'b1;
        cfg_index <= gwai_pkg::REG_GAIN_Q16;
        cfg_data  <= cfg_word_t'(gain);
        @(negedge clk);
        cfg_index <= gwai_pkg::REG_MAX_ANGLE;
        cfg_data  <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(gwai_pkg::REG_GAIN_Q16, cfg_word_t'(gain));
        tracker.set_reg(gwai_pkg::REG_MAX_ANGLE, word);
        reg_writes += 2;
    endtask

    // A rate is either a corner value, a uniform 16-bit value, or a value near
    // the window's trend so that averages stay large and the angles move.
    function automatic rate_t pick_rate(int trend);
        int v;
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            case ($urandom_range(8))
                0:       v = RATE_MAX;
                1:       v = RATE_MIN;
                2:       v = 0;
                3:       v = -1;
                4:       v = 1;
                5:       v = RATE_DIVISOR;
                6:       v = -RATE_DIVISOR;
                7:       v = RATE_DIVISOR - 1;
                default: v = 1 - RATE_DIVISOR;
            endcase
        end
        else if (r < 50)
            v = int'($urandom_range(65535)) + RATE_MIN;
        else
            v = trend + int'($urandom_range(4000)) - 2000;
        if (v > RATE_MAX)
            v = RATE_MAX;
        if (v < RATE_MIN)
            v = RATE_MIN;
        return rate_t'(v);
    endfunction

    // Random windows: mostly short ones, some longer, the last one cut to the
    // item budget. Now and then the registers change, or the sender waits for
    // the results.
    task automatic run_windows(input int n_items);
        int     sent;
        int     len;
        int     pick;
        int     trend[3];
        gain_t  gain;
        angle_t ceiling;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                case ($urandom_range(3))
                    0:       gain = gwai_pkg::GAIN_RESET;
                    1:       gain = '1;
                    2:       gain = '0;
                    default: gain = gain_t'($urandom());
                endcase
                case ($urandom_range(3))
                    0:       ceiling = gwai_pkg::MAX_RESET;
                    1:       ceiling = '1;
                    2:       ceiling = angle_t'($urandom());
                    default: ceiling = angle_t'($urandom_range(255, 100));
                endcase
                configure(gain, ceiling);
            end
            else if (pick < 7)
                drain();
            pick = $urandom_range(99);
            if (pick < 75)
                len = $urandom_range(6, 1);
            else
                len = $urandom_range(24, 7);
            if (len > n_items - sent)
                len = n_items - sent;
            foreach (trend[a])
                trend[a] = int'($urandom_range(65535)) + RATE_MIN;
            for (int i = 0; i < len; i++)
                send_sample(pick_rate(trend[0]), pick_rate(trend[1]), pick_rate(trend[2]),
                            i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, default registers first: full-scale rates both ways,
        // a three-sample window with values around the divisor, a zero window.
        send_sample(rate_t'(RATE_MAX), rate_t'(RATE_MAX), rate_t'(RATE_MAX), 1'b1);
        send_sample(rate_t'(RATE_MIN), rate_t'(RATE_MIN), rate_t'(RATE_MIN), 1'b1);
        send_sample(rate_t'(RATE_MAX), rate_t'(RATE_MIN), rate_t'(0), 1'b0);
        send_sample(rate_t'(RATE_DIVISOR), rate_t'(-RATE_DIVISOR), rate_t'(RATE_DIVISOR - 1),
                    1'b0);
        send_sample(rate_t'(-1), rate_t'(1), rate_t'(1 - RATE_DIVISOR), 1'b1);
        send_sample(rate_t'(0), rate_t'(0), rate_t'(0), 1'b1);

        // Full gain and full range: tilt runs into the top clamp and pitch
        // into the bottom one, then both are pushed further against them.
        configure('1, '1);
        send_sample(rate_t'(RATE_MAX), rate_t'(RATE_MIN), rate_t'(RATE_DIVISOR), 1'b1);
        send_sample(rate_t'(RATE_MAX), rate_t'(RATE_MIN), rate_t'(-RATE_DIVISOR), 1'b1);

        // Lowering the ceiling below a held angle only takes effect at the
        // next window end, even when the change itself is zero.
        configure('1, angle_t'(40));
        send_sample(rate_t'(0), rate_t'(0), rate_t'(0), 1'b1);

        // Zero gain with a zero ceiling pins everything at zero.
        configure('0, '0);
        send_sample(rate_t'(RATE_MAX), rate_t'(RATE_MAX), rate_t'(RATE_MAX), 1'b1);

        // Top gain bit alone, with a multi-sample window of mixed signs.
        configure(gain_t'(1) << (gwai_pkg::GAIN_W - 1), '1);
        send_sample(rate_t'(20000), rate_t'(-20000), rate_t'(5000), 1'b0);
        send_sample(rate_t'(20000), rate_t'(-20000), rate_t'(5000), 1'b0);
        send_sample(rate_t'(-300), rate_t'(300), rate_t'(-7000), 1'b1);

        // Random part in three idling phases.
        send_idle_pct = 7;
        recv_idle_pct = 67;
        configure(gain_t'(6000), gwai_pkg::MAX_RESET);
        run_windows(30);

        send_idle_pct = 67;
        recv_idle_pct = 7;
        configure('1, angle_t'(120));
        run_windows(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(gwai_pkg::GAIN_RESET, gwai_pkg::MAX_RESET);
        run_windows(30);

        // One window long enough to saturate the sample count; the samples
        // past the limit must not reach the sums.
        for (int i = 0; i < MAX_SAMPLES + 6; i++)
            send_sample(pick_rate(20000), pick_rate(-20000), pick_rate(0),
                        i == MAX_SAMPLES + 5);

        drain();
        $display("Sent %0d gyro samples in %0d windows and checked %0d angle results.",
                 samples_sent, tracker.windows, tracker.checked);
        $display("Made %0d register writes; %0d window(s) closed with the count saturated.",
                 reg_writes, tracker.saturated_windows);
        if (tracker.errors == 0 && tracker.pending_angles.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: gyro_window_angle_integrator.f
sv/gwai_pkg.sv
sv/gwai_div.sv
sv/gwai_lane.sv
sv/gyro_window_angle_integrator.sv
sim/testbench.sv
